@@ design/kwm_pkg.sv @@
package kwm_pkg;

    // Fixed field widths of the merge block
    localparam int LIST_BITS = 3;
    localparam int CFG_BITS  = 4;

    // Reset value of the list count register
    localparam logic [CFG_BITS-1:0] LIST_COUNT_RESET = 4'd8;

endpackage

@@ design/kwm_ram.sv @@
module kwm_ram #(
    parameter int WIDTH = 35,
    parameter int DEPTH = 8
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        // Hold read data until the next read on that port
        if (re_a)
        begin
            rdata_a <= mem[raddr_a];
        end
        if (re_b)
        begin
            rdata_b <= mem[raddr_b];
        end
    end

endmodule

@@ design/kwm_cmp.sv @@
module kwm_cmp #(
    parameter int VALUE_BITS = 32
) (
    input  logic [VALUE_BITS+kwm_pkg::LIST_BITS-1:0] a,
    input  logic [VALUE_BITS+kwm_pkg::LIST_BITS-1:0] b,
    output logic                                      a_less
);

    logic signed [VALUE_BITS-1:0]       a_val;
    logic signed [VALUE_BITS-1:0]       b_val;
    logic [kwm_pkg::LIST_BITS-1:0]      a_list;
    logic [kwm_pkg::LIST_BITS-1:0]      b_list;

    assign a_val  = a[VALUE_BITS+kwm_pkg::LIST_BITS-1:kwm_pkg::LIST_BITS];
    assign b_val  = b[VALUE_BITS+kwm_pkg::LIST_BITS-1:kwm_pkg::LIST_BITS];
    assign a_list = a[kwm_pkg::LIST_BITS-1:0];
    assign b_list = b[kwm_pkg::LIST_BITS-1:0];

    // Order by signed value, break ties toward the lower list number
    always_comb
    begin
        if (a_val != b_val)
        begin
            a_less = (a_val < b_val);
        end
        else
        begin
            a_less = (a_list < b_list);
        end
    end

endmodule

@@ design/k_way_merge_min_heap.sv @@
// Channel   Beat signals                    Handshake
// -------   ------------------------------  -----------------------------
// in        kind, list_id, value            in_valid / in_ready
// out       merged_value, source_list,      out_valid / out_ready
//           finished
// cfg       cfg_wr_data (list count)        cfg_wr_en, no wait
//
// One input beat at a time: in_ready is high only while the sequencer is idle.
// The heap sits in a small RAM and one comparator serves every step. A push
// writes the root directly, else reads and compares each parent in turn. A pop
// reads root and last entry, then per child round reads, compares left and
// right, settles at a leaf and loads the output register; a finish marker goes
// straight there. Delivery holds while the output is full. Reset skips the RAM.
module k_way_merge_min_heap #(
    parameter int MAX_LISTS  = 8,
    parameter int VALUE_BITS = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [kwm_pkg::CFG_BITS-1:0]       cfg_wr_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               kind,
    input  logic [kwm_pkg::LIST_BITS-1:0]      list_id,
    input  logic signed [VALUE_BITS-1:0]       value,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [VALUE_BITS-1:0]       merged_value,
    output logic [kwm_pkg::LIST_BITS-1:0]      source_list,
    output logic                               finished
);

    localparam int AW = $clog2(MAX_LISTS);       // heap address bits
    localparam int CW = $clog2(MAX_LISTS + 1);   // heap count bits
    localparam int XW = AW + 2;                  // child index bits
    localparam int LB = kwm_pkg::LIST_BITS;
    localparam int IW = VALUE_BITS + LB;         // heap entry {value, list}

    typedef enum logic [1:0] {
        PH_LOAD  = 2'd0,
        PH_MERGE = 2'd1,
        PH_DONE  = 2'd2
    } phase_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_PUSH_RD,
        S_PUSH_CMP,
        S_POP,
        S_POP_LD,
        S_SIFT_RD,
        S_SIFT_L,
        S_SIFT_R,
        S_DELIVER
    } state_t;

    // Sequencer and merge control
    state_t                        state_reg, state_next;
    phase_t                        phase_reg, phase_next;
    logic [CW-1:0]                 count_reg, count_next;
    logic [kwm_pkg::CFG_BITS-1:0]  reported_reg, reported_next;
    logic [LB-1:0]                 awaiting_reg, awaiting_next;
    logic [kwm_pkg::CFG_BITS-1:0]  list_count_reg;
    logic                          emit_reg, emit_next;

    // Working item registers
    logic [IW-1:0]                 new_reg, new_next;
    logic [IW-1:0]                 last_reg, last_next;
    logic [IW-1:0]                 cand_reg, cand_next;
    logic [AW-1:0]                 hole_reg, hole_next;
    logic [AW-1:0]                 cand_idx_reg, cand_idx_next;
    logic                          cand_child_reg, cand_child_next;
    logic                          r_ok_reg, r_ok_next;

    // Pending result and output register
    logic [VALUE_BITS-1:0]         res_val_reg, res_val_next;
    logic [LB-1:0]                 res_list_reg, res_list_next;
    logic                          res_fin_reg, res_fin_next;
    logic                          out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0]         merged_value_reg, merged_value_next;
    logic [LB-1:0]                 source_list_reg, source_list_next;
    logic                          finished_reg, finished_next;

    // RAM port signals
    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr;
    logic [IW-1:0]                 ram_wdata;
    logic                          ram_re_a, ram_re_b;
    logic [AW-1:0]                 ram_raddr_a, ram_raddr_b;
    logic [IW-1:0]                 ram_rdata_a, ram_rdata_b;

    // Shared comparator
    logic [IW-1:0]                 cmp_a, cmp_b;
    logic                          cmp_less;

    // Derived values
    logic [kwm_pkg::CFG_BITS-1:0]  eff_count;
    logic [kwm_pkg::CFG_BITS-1:0]  reported_inc;
    logic [AW-1:0]                 parent_idx;
    logic [XW-1:0]                 l_idx, r_idx, count_ext;
    logic                          in_beat;

    kwm_ram #(
        .WIDTH (IW),
        .DEPTH (MAX_LISTS)
    ) u_heap_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .re_a    (ram_re_a),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .re_b    (ram_re_b),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    kwm_cmp #(
        .VALUE_BITS (VALUE_BITS)
    ) u_cmp (
        .a      (cmp_a),
        .b      (cmp_b),
        .a_less (cmp_less)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign in_beat      = in_valid && in_ready;
    assign out_valid    = out_valid_reg;
    assign merged_value = merged_value_reg;
    assign source_list  = source_list_reg;
    assign finished     = finished_reg;

    // Clamp the list count: zero counts as one, anything above MAX_LISTS as MAX_LISTS
    always_comb
    begin
        if (list_count_reg == '0)
        begin
            eff_count = kwm_pkg::CFG_BITS'(1);
        end
        else if (32'(list_count_reg) > MAX_LISTS)
        begin
            eff_count = kwm_pkg::CFG_BITS'(MAX_LISTS);
        end
        else
        begin
            eff_count = list_count_reg;
        end
    end

    assign reported_inc = reported_reg + kwm_pkg::CFG_BITS'(1);
    assign parent_idx   = AW'((hole_reg - AW'(1)) >> 1);
    assign l_idx        = {1'b0, hole_reg, 1'b1};
    assign r_idx        = l_idx + XW'(1);
    assign count_ext    = XW'(count_reg);

    // Steer the one comparator by sequencer step
    always_comb
    begin
        cmp_a = new_reg;
        cmp_b = ram_rdata_a;
        case (state_reg)
            S_SIFT_L:
            begin
                cmp_a = ram_rdata_a;
                cmp_b = last_reg;
            end
            S_SIFT_R:
            begin
                cmp_a = ram_rdata_b;
                cmp_b = cand_reg;
            end
            default:
            begin
                cmp_a = new_reg;
                cmp_b = ram_rdata_a;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        phase_next        = phase_reg;
        count_next        = count_reg;
        reported_next     = reported_reg;
        awaiting_next     = awaiting_reg;
        emit_next         = emit_reg;
        new_next          = new_reg;
        last_next         = last_reg;
        cand_next         = cand_reg;
        hole_next         = hole_reg;
        cand_idx_next     = cand_idx_reg;
        cand_child_next   = cand_child_reg;
        r_ok_next         = r_ok_reg;
        res_val_next      = res_val_reg;
        res_list_next     = res_list_reg;
        res_fin_next      = res_fin_reg;
        merged_value_next = merged_value_reg;
        source_list_next  = source_list_reg;
        finished_next     = finished_reg;
        ram_we            = 1'b0;
        ram_waddr         = hole_reg;
        ram_wdata         = new_reg;
        ram_re_a          = 1'b0;
        ram_raddr_a       = parent_idx;
        ram_re_b          = 1'b0;
        ram_raddr_b       = '0;

        // Drop the output beat once taken
        out_valid_next = out_valid_reg && !out_ready;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_beat)
                begin
                    new_next = {value, list_id};
                    if (phase_reg == PH_LOAD)
                    begin
                        if ({1'b0, list_id} == reported_reg)
                        begin
                            reported_next = reported_inc;
                            emit_next     = (reported_inc >= eff_count);
                            if (!kind && (count_reg < CW'(MAX_LISTS)))
                            begin
                                hole_next  = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                                state_next = S_PUSH_RD;
                            end
                            else if (reported_inc >= eff_count)
                            begin
                                state_next = S_POP;
                            end
                        end
                    end
                    else if (phase_reg == PH_MERGE)
                    begin
                        if (list_id == awaiting_reg)
                        begin
                            emit_next = 1'b1;
                            if (!kind && (count_reg < CW'(MAX_LISTS)))
                            begin
                                hole_next  = count_reg[AW-1:0];
                                count_next = count_reg + CW'(1);
                                state_next = S_PUSH_RD;
                            end
                            else
                            begin
                                state_next = S_POP;
                            end
                        end
                    end
                end
            end

            S_PUSH_RD:
            begin
                if (hole_reg == '0)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = hole_reg;
                    ram_wdata  = new_reg;
                    state_next = emit_reg ? S_POP : S_IDLE;
                end
                else
                begin
                    ram_re_a    = 1'b1;
                    ram_raddr_a = parent_idx;
                    state_next  = S_PUSH_CMP;
                end
            end

            S_PUSH_CMP:
            begin
                ram_we    = 1'b1;
                ram_waddr = hole_reg;
                if (cmp_less)
                begin
                    // Move the parent down and climb
                    ram_wdata  = ram_rdata_a;
                    hole_next  = parent_idx;
                    state_next = S_PUSH_RD;
                end
                else
                begin
                    ram_wdata  = new_reg;
                    state_next = emit_reg ? S_POP : S_IDLE;
                end
            end

            S_POP:
            begin
                if (count_reg == '0)
                begin
                    res_val_next  = '0;
                    res_list_next = '0;
                    res_fin_next  = 1'b1;
                    phase_next    = PH_DONE;
                    state_next    = S_DELIVER;
                end
                else
                begin
                    ram_re_a    = 1'b1;
                    ram_raddr_a = '0;
                    ram_re_b    = 1'b1;
                    ram_raddr_b = AW'(count_reg - CW'(1));
                    count_next  = count_reg - CW'(1);
                    state_next  = S_POP_LD;
                end
            end

            S_POP_LD:
            begin
                res_val_next  = ram_rdata_a[IW-1:LB];
                res_list_next = ram_rdata_a[LB-1:0];
                res_fin_next  = 1'b0;
                awaiting_next = ram_rdata_a[LB-1:0];
                phase_next    = PH_MERGE;
                last_next     = ram_rdata_b;
                hole_next     = '0;
                state_next    = S_SIFT_RD;
            end

            S_SIFT_RD:
            begin
                if (l_idx >= count_ext)
                begin
                    // Leaf reached: settle the former last entry here
                    if (count_reg != '0)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = hole_reg;
                        ram_wdata = last_reg;
                    end
                    state_next = S_DELIVER;
                end
                else
                begin
                    ram_re_a    = 1'b1;
                    ram_raddr_a = l_idx[AW-1:0];
                    ram_re_b    = (r_idx < count_ext);
                    ram_raddr_b = r_idx[AW-1:0];
                    r_ok_next   = (r_idx < count_ext);
                    state_next  = S_SIFT_L;
                end
            end

            S_SIFT_L:
            begin
                if (cmp_less)
                begin
                    cand_next       = ram_rdata_a;
                    cand_idx_next   = l_idx[AW-1:0];
                    cand_child_next = 1'b1;
                end
                else
                begin
                    cand_next       = last_reg;
                    cand_child_next = 1'b0;
                end
                state_next = S_SIFT_R;
            end

            S_SIFT_R:
            begin
                ram_we    = 1'b1;
                ram_waddr = hole_reg;
                if (r_ok_reg && cmp_less)
                begin
                    ram_wdata  = ram_rdata_b;
                    hole_next  = r_idx[AW-1:0];
                    state_next = S_SIFT_RD;
                end
                else if (cand_child_reg)
                begin
                    ram_wdata  = cand_reg;
                    hole_next  = cand_idx_reg;
                    state_next = S_SIFT_RD;
                end
                else
                begin
                    ram_wdata  = last_reg;
                    state_next = S_DELIVER;
                end
            end

            S_DELIVER:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next    = 1'b1;
                    merged_value_next = res_val_reg;
                    source_list_next  = res_list_reg;
                    finished_next     = res_fin_reg;
                    emit_next         = 1'b0;
                    state_next        = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            phase_reg        <= PH_LOAD;
            count_reg        <= '0;
            reported_reg     <= '0;
            awaiting_reg     <= '0;
            list_count_reg   <= kwm_pkg::LIST_COUNT_RESET;
            emit_reg         <= 1'b0;
            out_valid_reg    <= 1'b0;
            new_reg          <= '0;
            last_reg         <= '0;
            cand_reg         <= '0;
            hole_reg         <= '0;
            cand_idx_reg     <= '0;
            cand_child_reg   <= 1'b0;
            r_ok_reg         <= 1'b0;
            res_val_reg      <= '0;
            res_list_reg     <= '0;
            res_fin_reg      <= 1'b0;
            merged_value_reg <= '0;
            source_list_reg  <= '0;
            finished_reg     <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            phase_reg        <= phase_next;
            count_reg        <= count_next;
            reported_reg     <= reported_next;
            awaiting_reg     <= awaiting_next;
            emit_reg         <= emit_next;
            out_valid_reg    <= out_valid_next;
            new_reg          <= new_next;
            last_reg         <= last_next;
            cand_reg         <= cand_next;
            hole_reg         <= hole_next;
            cand_idx_reg     <= cand_idx_next;
            cand_child_reg   <= cand_child_next;
            r_ok_reg         <= r_ok_next;
            res_val_reg      <= res_val_next;
            res_list_reg     <= res_list_next;
            res_fin_reg      <= res_fin_next;
            merged_value_reg <= merged_value_next;
            source_list_reg  <= source_list_next;
            finished_reg     <= finished_next;
            if (cfg_wr_en)
            begin
                list_count_reg <= cfg_wr_data;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(MAX_LISTS))
        else $error("heap count above capacity");

    a_write_in_heap: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (CW'(ram_waddr) < count_reg))
        else $error("heap write outside occupied entries");

    a_finish_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && finished_reg) |-> (phase_reg == PH_DONE))
        else $error("finished marker outside done phase");

    a_done_ignores: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && (phase_reg == PH_DONE)) |=> (state_reg == S_IDLE))
        else $error("beat after finish started work");
`endif

endmodule
